// ----- rtl/lfu_cache_table_defines.svh -----
// Assertion macros used by the top level of the cache table.
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfu_cache_table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfu_cache_table: next-cycle check failed");

`endif

// ----- rtl/lfu_pkg.sv -----
// Shared types and constants of the LFU cache table.
package lfu_pkg;

   localparam int KEY_W      = 64;
   localparam int DATA_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int STAMP_W    = 64;
   localparam int CAP_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR  = 2'd0;
   localparam logic [CAP_W-1:0]      CAPACITY_RESET = 5'd16;
   localparam logic [COUNT_W-1:0]    COUNT_MAX      = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic write;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic cap_zero;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- rtl/lfu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lfu_ctrl.sv -----
// Sequencer that steps each beat through lookup scan, write-back and result (result only at zero capacity).
module lfu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lfu_pkg::status_type status,
   output lfu_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_WRITE  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.cap_zero) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- rtl/lfu_dpath.sv -----
// Datapath: capacity register, entry RAM, valid bits, scan trackers, write-back and result register.
module lfu_dpath #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lfu_pkg::cmd_type                    cmd,
   output lfu_pkg::status_type                 status,
   input  logic                                req_op,
   input  logic signed [lfu_pkg::KEY_W-1:0]    req_key,
   input  logic signed [lfu_pkg::DATA_W-1:0]   req_value,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lfu_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic signed [lfu_pkg::DATA_W-1:0]   rsp_read_value,
   output logic                                rsp_evicted,
   output logic signed [lfu_pkg::KEY_W-1:0]    rsp_evicted_key
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CMP_W-1:0] ENT_X    = CMP_W'(ENTRIES);

   logic [lfu_pkg::CAP_W-1:0]   capacity_ff, capacity_in;
   logic                        op_ff, op_in;
   logic [lfu_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lfu_pkg::DATA_W-1:0]  value_ff, value_in;

   logic                        rd_active_ff, rd_active_in;
   logic [IDX_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]            cmp_idx_ff, cmp_idx_in;

   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            match_idx_ff, match_idx_in;
   logic [lfu_pkg::DATA_W-1:0]  match_data_ff, match_data_in;
   logic [lfu_pkg::COUNT_W-1:0] match_count_ff, match_count_in;

   logic                        vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]            vic_idx_ff, vic_idx_in;
   logic [lfu_pkg::KEY_W-1:0]   vic_key_ff, vic_key_in;
   logic [lfu_pkg::COUNT_W-1:0] vic_count_ff, vic_count_in;
   logic [lfu_pkg::STAMP_W-1:0] vic_stamp_ff, vic_stamp_in;

   logic                        free_found_ff, free_found_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic                        evict_ff, evict_in;

   logic [ENTRIES-1:0]          valid_ff, valid_in;
   logic [OCC_W-1:0]            occ_ff, occ_in;
   logic [lfu_pkg::STAMP_W-1:0] stamp_ff, stamp_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [lfu_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                        rsp_evicted_ff, rsp_evicted_in;
   logic [lfu_pkg::KEY_W-1:0]   rsp_evkey_ff, rsp_evkey_in;

   lfu_pkg::entry_type          rd_entry;
   lfu_pkg::entry_type          wr_entry;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_slot;
   logic                        entry_ok;
   logic                        full;
   logic                        do_evict;
   logic                        do_insert;
   logic                        csr_write;

   lfu_ram #(
      .WIDTH ($bits(lfu_pkg::entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (wr_entry),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_entry)
   );

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == lfu_pkg::CAPACITY_ADDR) ?
                       lfu_pkg::CSR_DATA_W'(capacity_ff) : '0;

   assign entry_ok = valid_ff[cmp_idx_ff];
   assign full = (CMP_W'(occ_ff) >= CMP_W'(capacity_ff)) || (CMP_W'(occ_ff) >= ENT_X);
   assign do_evict  = (op_ff == lfu_pkg::OP_SET) && !hit_ff && full && vic_found_ff;
   assign do_insert = (op_ff == lfu_pkg::OP_SET) && !hit_ff && (do_evict || free_found_ff);
   assign wr_slot = hit_ff ? match_idx_ff : (do_evict ? vic_idx_ff : free_idx_ff);
   assign wr_en   = cmd.write && (hit_ff || do_insert);

   always_comb begin
      wr_entry.key   = key_ff;
      wr_entry.stamp = stamp_ff;
      if (hit_ff) begin
         wr_entry.data  = (op_ff == lfu_pkg::OP_SET) ? value_ff : match_data_ff;
         wr_entry.count = (match_count_ff == lfu_pkg::COUNT_MAX) ?
                          lfu_pkg::COUNT_MAX : match_count_ff + lfu_pkg::COUNT_W'(1);
      end else begin
         wr_entry.data  = value_ff;
         wr_entry.count = lfu_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      capacity_in    = capacity_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      rd_active_in   = rd_active_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_valid_in   = rd_active_ff;
      cmp_idx_in     = rd_idx_ff;
      hit_in         = hit_ff;
      match_idx_in   = match_idx_ff;
      match_data_in  = match_data_ff;
      match_count_in = match_count_ff;
      vic_found_in   = vic_found_ff;
      vic_idx_in     = vic_idx_ff;
      vic_key_in     = vic_key_ff;
      vic_count_in   = vic_count_ff;
      vic_stamp_in   = vic_stamp_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      evict_in       = evict_ff;
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      stamp_in       = stamp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evkey_in   = rsp_evkey_ff;

      if (csr_write && (csr_paddr == lfu_pkg::CAPACITY_ADDR)) begin
         capacity_in = csr_pwdata[lfu_pkg::CAP_W-1:0];
      end

      if (cmd.load) begin
         op_in         = req_op;
         key_in        = req_key;
         value_in      = req_value;
         hit_in        = 1'b0;
         vic_found_in  = 1'b0;
         free_found_in = 1'b0;
         evict_in      = 1'b0;
      end

      if (cmd.scan_start) begin
         rd_active_in = 1'b1;
         rd_idx_in    = '0;
      end else if (rd_active_ff) begin
         if (rd_idx_ff == LAST_IDX) begin
            rd_active_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
      end

      if (cmp_valid_ff) begin
         if (entry_ok && !hit_ff && (rd_entry.key == key_ff)) begin
            hit_in         = 1'b1;
            match_idx_in   = cmp_idx_ff;
            match_data_in  = rd_entry.data;
            match_count_in = rd_entry.count;
         end
         if (entry_ok && (!vic_found_ff || (rd_entry.count < vic_count_ff) ||
             ((rd_entry.count == vic_count_ff) && (rd_entry.stamp < vic_stamp_ff)))) begin
            vic_found_in = 1'b1;
            vic_idx_in   = cmp_idx_ff;
            vic_key_in   = rd_entry.key;
            vic_count_in = rd_entry.count;
            vic_stamp_in = rd_entry.stamp;
         end
         if (!entry_ok && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
      end

      if (cmd.write) begin
         evict_in = do_evict;
         if (hit_ff || do_insert) begin
            stamp_in = stamp_ff + lfu_pkg::STAMP_W'(1);
         end
         if (do_insert) begin
            valid_in[wr_slot] = 1'b1;
            if (!do_evict) begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
      end

      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = hit_ff;
         rsp_evicted_in = evict_ff;
         rsp_evkey_in   = evict_ff ? vic_key_ff : '0;
         if (hit_ff) begin
            rsp_value_in = match_data_ff;
         end else if (op_ff == lfu_pkg::OP_SET) begin
            rsp_value_in = '0;
         end else begin
            rsp_value_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= lfu_pkg::CAPACITY_RESET;
         rd_active_ff  <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         evict_ff      <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
         stamp_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         rd_active_ff  <= rd_active_in;
         cmp_valid_ff  <= cmp_valid_in;
         hit_ff        <= hit_in;
         vic_found_ff  <= vic_found_in;
         free_found_ff <= free_found_in;
         evict_ff      <= evict_in;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         stamp_ff      <= stamp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      match_idx_ff   <= match_idx_in;
      match_data_ff  <= match_data_in;
      match_count_ff <= match_count_in;
      vic_idx_ff     <= vic_idx_in;
      vic_key_ff     <= vic_key_in;
      vic_count_ff   <= vic_count_in;
      vic_stamp_ff   <= vic_stamp_in;
      free_idx_ff    <= free_idx_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evkey_ff   <= rsp_evkey_in;
   end

   assign status.cap_zero  = (capacity_ff == '0);
   assign status.scan_done = cmp_valid_ff && (cmp_idx_ff == LAST_IDX);
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

endmodule

// ----- rtl/lfu_cache_table.sv -----
// Top level of the LFU cache table: sequencer, datapath and configuration port.
// Each beat reads one slot per cycle from the entry RAM (registered read), then compares the last
// slot, does the write-back and loads the result register. A new beat is taken only once the
// sequencer is back in idle, after the previous result was loaded, so loading waits while an
// earlier result is stalled; with zero capacity the scan and write-back are skipped.
// Synchronous reset empties the table, zeroes the stamp and sets capacity to 16.
`include "lfu_cache_table_defines.svh"

module lfu_cache_table #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [lfu_pkg::KEY_W-1:0]    req_key,
   input  logic signed [lfu_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic signed [lfu_pkg::DATA_W-1:0]   rsp_read_value,
   output logic                                rsp_evicted,
   output logic signed [lfu_pkg::KEY_W-1:0]    rsp_evicted_key,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lfu_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   lfu_pkg::cmd_type    cmd;
   lfu_pkg::status_type status;

   assign csr_pready = 1'b1;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_value       (req_value),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

   `LFU_ASSERT_SAME(a_load_on_accept, clock, reset, cmd.load, req_valid && !req_stall)
   `LFU_ASSERT_SAME(a_scan_while_busy, clock, reset, status.scan_done, req_stall)
   `LFU_ASSERT_NEXT(a_single_write, clock, reset, cmd.write, !cmd.write)
   `LFU_ASSERT_NEXT(a_emit_shows_result, clock, reset, cmd.emit, rsp_valid)

endmodule

// ----- verif/lfu_cache_checker.sv -----
// Checker for the LFU cache table: tracks the table, predicts each response beat and compares it.
module lfu_cache_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_op,
   input  logic [lfu_pkg::KEY_W-1:0]      req_key,
   input  logic [lfu_pkg::DATA_W-1:0]     req_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_hit,
   input  logic [lfu_pkg::DATA_W-1:0]     rsp_read_value,
   input  logic                           rsp_evicted,
   input  logic [lfu_pkg::KEY_W-1:0]      rsp_evicted_key,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             pending,
   output int                             mismatches,
   output int                             hit_total,
   output int                             evict_total
);

   typedef struct packed {
      logic                       hit;
      logic [lfu_pkg::DATA_W-1:0] read_value;
      logic                       evicted;
      logic [lfu_pkg::KEY_W-1:0]  evicted_key;
   } cache_answer_type;

   logic                        slot_valid [ENTRIES];
   logic [lfu_pkg::KEY_W-1:0]   slot_key   [ENTRIES];
   logic [lfu_pkg::DATA_W-1:0]  slot_data  [ENTRIES];
   logic [lfu_pkg::COUNT_W-1:0] slot_count [ENTRIES];
   logic [lfu_pkg::STAMP_W-1:0] slot_stamp [ENTRIES];
   logic [lfu_pkg::STAMP_W-1:0] stamp_now;
   logic [lfu_pkg::CAP_W-1:0]   cap_reg;
   int                          fill;
   int                          bad;
   int                          hits;
   int                          evicts;
   cache_answer_type            answer_q [$];

   function automatic cache_answer_type access_cache(input logic op,
                                                     input logic [lfu_pkg::KEY_W-1:0] k,
                                                     input logic [lfu_pkg::DATA_W-1:0] v);
      cache_answer_type ans;
      int               limit;
      int               slot;
      ans.hit         = 1'b0;
      ans.read_value  = (op == lfu_pkg::OP_SET) ? '0 : '1;
      ans.evicted     = 1'b0;
      ans.evicted_key = '0;
      limit = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
      slot  = -1;
      if (limit != 0) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && slot_valid[i] && slot_key[i] == k) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            ans.hit        = 1'b1;
            ans.read_value = slot_data[slot];
            if (op == lfu_pkg::OP_SET) begin
               slot_data[slot] = v;
            end
            if (slot_count[slot] != lfu_pkg::COUNT_MAX) begin
               slot_count[slot] = slot_count[slot] + 1'b1;
            end
            slot_stamp[slot] = stamp_now;
            stamp_now        = stamp_now + 1'b1;
         end else if (op == lfu_pkg::OP_SET) begin
            if (fill >= limit) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
                      (slot_count[i] == slot_count[slot] &&
                       slot_stamp[i] < slot_stamp[slot]))) begin
                     slot = i;
                  end
               end
               if (slot >= 0) begin
                  ans.evicted      = 1'b1;
                  ans.evicted_key  = slot_key[slot];
                  slot_valid[slot] = 1'b0;
                  fill             = fill - 1;
               end
            end
            if (slot < 0) begin
               for (int i = ENTRIES - 1; i >= 0; i--) begin
                  if (!slot_valid[i]) begin
                     slot = i;
                  end
               end
            end
            if (slot >= 0) begin
               slot_valid[slot] = 1'b1;
               slot_key[slot]   = k;
               slot_data[slot]  = v;
               slot_count[slot] = lfu_pkg::COUNT_W'(1);
               slot_stamp[slot] = stamp_now;
               stamp_now        = stamp_now + 1'b1;
               fill             = fill + 1;
            end
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      cache_answer_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
         end
         stamp_now = '0;
         cap_reg   = lfu_pkg::CAPACITY_RESET;
         fill      = 0;
         bad       = 0;
         hits      = 0;
         evicts    = 0;
         answer_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == lfu_pkg::CAPACITY_ADDR) begin
            cap_reg = csr_pwdata[lfu_pkg::CAP_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               bad++;
               if (bad <= 10) begin
                  $display("Response beat with nothing outstanding: hit %0b read_value %h",
                           rsp_hit, rsp_read_value);
               end
            end else begin
               want = answer_q.pop_front();
               if (rsp_hit !== want.hit || rsp_read_value !== want.read_value ||
                   rsp_evicted !== want.evicted || rsp_evicted_key !== want.evicted_key) begin
                  bad++;
                  if (bad <= 10) begin
                     $display("Mismatch (expected/actual): hit %0b/%0b read_value %h/%h",
                              want.hit, rsp_hit, want.read_value, rsp_read_value);
                     $display("   evicted %0b/%0b evicted_key %h/%h",
                              want.evicted, rsp_evicted, want.evicted_key, rsp_evicted_key);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = access_cache(req_op, req_key, req_value);
            answer_q.push_back(want);
            if (want.hit) begin
               hits++;
            end
            if (want.evicted) begin
               evicts++;
            end
         end
      end
      pending     <= answer_q.size();
      mismatches  <= bad;
      hit_total   <= hits;
      evict_total <= evicts;
   end

endmodule

// ----- verif/testbench.sv -----
// Top of the LFU cache table testbench: clock, reset, stimulus, capacity writes and verdict.
module testbench;

   localparam int                          PHASES   = 13;
   localparam int                          PHASE_CAP [PHASES] = '{16, 3, 1, 0, 31, 8, 17, 2,
                                                                  16, 5, 12, 0, 16};
   localparam logic [lfu_pkg::KEY_W-1:0]   WORD_MIN = 64'h8000_0000_0000_0000;
   localparam logic [lfu_pkg::KEY_W-1:0]   WORD_MAX = 64'h7fff_ffff_ffff_ffff;

   logic                             clock           = 1'b0;
   logic                             reset           = 1'b1;
   logic                             req_valid       = 1'b0;
   logic                             req_stall;
   logic                             req_op          = lfu_pkg::OP_GET;
   logic [lfu_pkg::KEY_W-1:0]        req_key         = '0;
   logic [lfu_pkg::DATA_W-1:0]       req_value       = '0;
   logic                             rsp_valid;
   logic                             rsp_stall       = 1'b0;
   logic                             rsp_hit;
   logic [lfu_pkg::DATA_W-1:0]       rsp_read_value;
   logic                             rsp_evicted;
   logic [lfu_pkg::KEY_W-1:0]        rsp_evicted_key;
   logic                             csr_psel        = 1'b0;
   logic                             csr_penable     = 1'b0;
   logic                             csr_pwrite      = 1'b0;
   logic [lfu_pkg::CSR_ADDR_W-1:0]   csr_paddr       = '0;
   logic [lfu_pkg::CSR_DATA_W-1:0]   csr_pwdata      = '0;
   logic [lfu_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;
   int                               pending;
   int                               mismatches;
   int                               hit_total;
   int                               evict_total;
   int                               send_idle_pct   = 0;
   int                               recv_idle_pct   = 0;
   int                               beats_sent      = 0;
   int                               cap_writes      = 0;
   logic [lfu_pkg::KEY_W-1:0]        key_pool [40];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lfu_cache_table #(.ENTRIES(16)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   lfu_cache_checker #(.ENTRIES(16)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .pending         (pending),
      .mismatches      (mismatches),
      .hit_total       (hit_total),
      .evict_total     (evict_total)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_beat(input logic op, input logic [lfu_pkg::KEY_W-1:0] k,
                            input logic [lfu_pkg::DATA_W-1:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= k;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_capacity(input int cap);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= lfu_pkg::CAPACITY_ADDR;
      csr_pwdata  <= {(lfu_pkg::CSR_DATA_W - lfu_pkg::CAP_W)'($urandom()),
                      cap[lfu_pkg::CAP_W-1:0]};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cap_writes++;
   endtask

   function automatic logic [lfu_pkg::KEY_W-1:0] pick_key(input int cap);
      int span;
      span = (cap > 16 ? 16 : cap) * 2 + 2;
      if ($urandom_range(9) == 0) begin
         return {$urandom(), $urandom()};
      end
      if ($urandom_range(2) == 0) begin
         return key_pool[$urandom_range(span / 4 + 1)];
      end
      return key_pool[$urandom_range(span - 1)];
   endfunction

   function automatic logic [lfu_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(19))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   initial begin
      key_pool[0] = WORD_MIN;
      key_pool[1] = WORD_MAX;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int i = 4; i < 40; i++) begin
         key_pool[i] = {$urandom(), $urandom()};
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 17;
      recv_idle_pct <= 53;

      send_beat(lfu_pkg::OP_GET, WORD_MIN, '0);
      send_beat(lfu_pkg::OP_SET, WORD_MIN, WORD_MAX);
      send_beat(lfu_pkg::OP_SET, WORD_MAX, WORD_MIN);
      send_beat(lfu_pkg::OP_SET, '0, '0);
      send_beat(lfu_pkg::OP_SET, '1, '1);
      send_beat(lfu_pkg::OP_GET, WORD_MIN, WORD_MAX);
      send_beat(lfu_pkg::OP_SET, WORD_MAX, 64'h0123_4567_89ab_cdef);
      send_beat(lfu_pkg::OP_GET, WORD_MAX, '1);
      send_beat(lfu_pkg::OP_GET, '0, WORD_MIN);
      send_beat(lfu_pkg::OP_GET, 64'h0000_0000_0000_0005, '0);
      // Capacity drops below the four entries held, so each new key evicts one.
      write_capacity(2);
      send_beat(lfu_pkg::OP_SET, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_beat(lfu_pkg::OP_SET, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_beat(lfu_pkg::OP_GET, 64'haaaa_aaaa_aaaa_aaaa, '0);
      // With the cache disabled every access misses and the contents are kept.
      write_capacity(0);
      send_beat(lfu_pkg::OP_GET, WORD_MAX, '0);
      send_beat(lfu_pkg::OP_SET, 64'h0000_0000_0000_0077, WORD_MAX);
      write_capacity(31);
      send_beat(lfu_pkg::OP_GET, WORD_MAX, '0);
      send_beat(lfu_pkg::OP_SET, 64'h0000_0000_0000_0077, WORD_MIN);
      send_beat(lfu_pkg::OP_SET, WORD_MIN, '1);
      write_capacity(1);
      send_beat(lfu_pkg::OP_SET, 64'hdead_beef_0000_0001, '1);
      send_beat(lfu_pkg::OP_GET, 64'hdead_beef_0000_0001, '0);
      send_beat(lfu_pkg::OP_GET, WORD_MIN, '0);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            send_idle_pct = 17;
            recv_idle_pct <= 53;
         end else if (p == 5) begin
            send_idle_pct = 53;
            recv_idle_pct <= 17;
         end else if (p == 9) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         write_capacity(PHASE_CAP[p]);
         repeat (100) begin
            send_beat(1'($urandom_range(1)), pick_key(PHASE_CAP[p]), pick_value());
         end
      end

      drain();
      repeat (60) @(posedge clock);
      $display("Summary: %0d request beats sent across %0d capacity writes (0 to 31).",
               beats_sent, cap_writes);
      $display("Summary: %0d hits and %0d evictions predicted, %0d mismatches.",
               hit_total, evict_total, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d response beats outstanding.", pending);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_ctrl.sv
rtl/lfu_dpath.sv
rtl/lfu_cache_table.sv
verif/lfu_cache_checker.sv
verif/testbench.sv
